/* sv/msrc_pkg.sv */
// msrc_pkg: shared types, constants and the crc-16 byte step for the modbus reply checker
// no dependencies; used by the channel interfaces and every module of the block
`default_nettype none

package msrc_pkg;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_ADDR_ERR  = 2'd1,
		STATUS_CRC_ERR   = 2'd2,
		STATUS_RX_FAILED = 2'd3
	} status_t;

	typedef struct packed {
		status_t            status;
		logic [15:0]        humidity;
		logic signed [15:0] temperature;
		logic [15:0]        noise;
	} result_t;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// byte positions inside the reply
	localparam int CRC_SPAN    = 29;
	localparam int HUM_HI_POS  = 3;
	localparam int HUM_LO_POS  = 4;
	localparam int TEMP_HI_POS = 5;
	localparam int TEMP_LO_POS = 6;
	localparam int NOISE_HI_POS = 27;
	localparam int NOISE_LO_POS = 28;

	// one byte through the reflected modbus crc
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] crc;
		crc = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage

`default_nettype wire

/* sv/msrc_if.sv */
// msrc_req_if and msrc_res_if: valid/ready channels of the modbus reply checker
// depends on msrc_pkg for the result payload types
`default_nettype none

interface msrc_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;
	logic       receive_failed;

	modport source (output valid, output rx_byte, output frame_start, output receive_failed,
		input ready);
	modport sink (input valid, input rx_byte, input frame_start, input receive_failed,
		output ready);
endinterface

interface msrc_res_if;
	logic                valid;
	logic                ready;
	msrc_pkg::status_t   status;
	logic [15:0]         humidity;
	logic signed [15:0]  temperature;
	logic [15:0]         noise;

	modport source (output valid, output status, output humidity, output temperature,
		output noise, input ready);
	modport sink (input valid, input status, input humidity, input temperature,
		input noise, output ready);
endinterface

`default_nettype wire

/* sv/msrc_result_buf.sv */
// msrc_result_buf: output register plus skid stage for result items
// depends on msrc_pkg for result_t
`default_nettype none

module msrc_result_buf (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic push,
	input  msrc_pkg::result_t  push_data,
	output logic               push_ready,
	output logic               out_valid,
	input  wire                logic out_ready,
	output msrc_pkg::result_t  out_data
);

	logic              out_valid_q;
	logic              skid_valid_q;
	msrc_pkg::result_t out_data_q;
	msrc_pkg::result_t skid_data_q;
	logic              pop;

	assign pop        = out_valid_q && out_ready;
	assign push_ready = !skid_valid_q;
	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_data_q <= push_data;
			end else begin
				skid_data_q <= push_data;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/modbus_sensor_reply_checker.sv */
// modbus_sensor_reply_checker: checks a fixed-length modbus rtu read-holding-registers reply
// depends on msrc_pkg, msrc_req_if / msrc_res_if and msrc_result_buf
//
//  channel   | direction | payload                                   | handshake
//  ----------+-----------+-------------------------------------------+-------------
//  req_ch    | in        | rx_byte, frame_start, receive_failed      | valid/ready
//  res_ch    | out       | status, humidity, temperature, noise      | valid/ready
//  cfg       | in        | cfg_wdata = slave_address                 | cfg_we only
//
// one request is taken per cycle while ready is high; its crc byte step, field capture and
// verdict all complete in the accepting cycle, so by the next cycle a result is in the
// output register or skid stage; the only stall source is the result side: a two-deep
// output register/skid stage keeps ready high until both places hold undelivered results
// reset clears the byte count, address flag and held values; crc to init, slave address to 1
`default_nettype none

module modbus_sensor_reply_checker #(
	parameter int FRAME_LENGTH = 31
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic [7:0] cfg_wdata,
	msrc_req_if.sink   req_ch,
	msrc_res_if.source res_ch
);

	// byte count runs 0..FRAME_LENGTH, the top value meaning idle
	localparam int IDX_W = $clog2(FRAME_LENGTH + 1);
	localparam logic [IDX_W-1:0] IDX_IDLE = IDX_W'(FRAME_LENGTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_LENGTH - 1);
	localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(FRAME_LENGTH - 2);

	logic [7:0]        slave_address_q;
	logic [IDX_W-1:0]  byte_index_q;
	logic [15:0]       crc_q;
	logic              addr_match_q;
	logic [7:0]        crc_low_q;
	logic [15:0]       frame_hum_q;
	logic [15:0]       frame_temp_q;
	logic [15:0]       frame_noise_q;
	logic [15:0]       held_hum_q;
	logic [15:0]       held_temp_q;
	logic [15:0]       held_noise_q;

	logic              accept;
	logic              failed;
	logic [IDX_W-1:0]  idx_cur;
	logic              active;
	logic              last_byte;
	logic [15:0]       crc_base;
	logic [15:0]       crc_next;
	logic              crc_good;
	logic              push;
	logic              push_ready;
	msrc_pkg::result_t push_data;
	msrc_pkg::result_t out_data;

	assign accept = req_ch.valid && req_ch.ready;
	assign failed = req_ch.receive_failed;

	// frame start forces byte zero; otherwise continue the running count
	assign idx_cur   = req_ch.frame_start ? '0 : byte_index_q;
	assign active    = accept && !failed && (idx_cur < IDX_IDLE);
	assign last_byte = active && (idx_cur == IDX_LAST);

	assign crc_base = (idx_cur == '0) ? msrc_pkg::CRC_INIT : crc_q;
	assign crc_next = msrc_pkg::crc_byte(crc_base, req_ch.rx_byte);

	// received crc is low byte first: low byte stored, high byte is the current one
	assign crc_good = (crc_q[7:0] == crc_low_q) && (crc_q[15:8] == req_ch.rx_byte);

	assign push = accept && (failed || last_byte);

	// verdict: link failure first, then address, then crc
	always_comb begin
		push_data.humidity    = held_hum_q;
		push_data.temperature = $signed(held_temp_q);
		push_data.noise       = held_noise_q;
		if (failed) begin
			push_data.status = msrc_pkg::STATUS_RX_FAILED;
		end else if (!addr_match_q) begin
			push_data.status = msrc_pkg::STATUS_ADDR_ERR;
		end else if (crc_good) begin
			push_data.status      = msrc_pkg::STATUS_OK;
			push_data.humidity    = frame_hum_q;
			push_data.temperature = $signed(frame_temp_q);
			push_data.noise       = frame_noise_q;
		end else begin
			push_data.status = msrc_pkg::STATUS_CRC_ERR;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= 8'd1;
			byte_index_q    <= '0;
			crc_q           <= msrc_pkg::CRC_INIT;
			addr_match_q    <= 1'b0;
			held_hum_q      <= '0;
			held_temp_q     <= '0;
			held_noise_q    <= '0;
		end else begin
			if (cfg_we) begin
				slave_address_q <= cfg_wdata;
			end
			if (accept && failed) begin
				byte_index_q <= IDX_IDLE;
			end else if (active) begin
				byte_index_q <= idx_cur + 1'b1;
				if (idx_cur < IDX_W'(msrc_pkg::CRC_SPAN)) begin
					crc_q <= crc_next;
				end else begin
					crc_q <= crc_base;
				end
				if (idx_cur == '0) begin
					addr_match_q <= (req_ch.rx_byte == slave_address_q);
				end
				// good frame: latch the new values as last-good
				if (last_byte && addr_match_q && crc_good) begin
					held_hum_q   <= frame_hum_q;
					held_temp_q  <= frame_temp_q;
					held_noise_q <= frame_noise_q;
				end
			end else if (accept && req_ch.frame_start) begin
				crc_q <= msrc_pkg::CRC_INIT;
			end
		end
	end

	// big-endian field capture and stored low crc byte
	always_ff @(posedge clk) begin
		if (active) begin
			if (idx_cur == IDX_W'(msrc_pkg::HUM_HI_POS)) frame_hum_q[15:8] <= req_ch.rx_byte;
			if (idx_cur == IDX_W'(msrc_pkg::HUM_LO_POS)) frame_hum_q[7:0] <= req_ch.rx_byte;
			if (idx_cur == IDX_W'(msrc_pkg::TEMP_HI_POS)) frame_temp_q[15:8] <= req_ch.rx_byte;
			if (idx_cur == IDX_W'(msrc_pkg::TEMP_LO_POS)) frame_temp_q[7:0] <= req_ch.rx_byte;
			if (idx_cur == IDX_W'(msrc_pkg::NOISE_HI_POS)) frame_noise_q[15:8] <= req_ch.rx_byte;
			if (idx_cur == IDX_W'(msrc_pkg::NOISE_LO_POS)) frame_noise_q[7:0] <= req_ch.rx_byte;
			if (idx_cur == IDX_CRC_LO) crc_low_q <= req_ch.rx_byte;
		end
	end

	msrc_result_buf u_result_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.out_valid  (res_ch.valid),
		.out_ready  (res_ch.ready),
		.out_data   (out_data)
	);

	assign req_ch.ready       = push_ready;
	assign res_ch.status      = out_data.status;
	assign res_ch.humidity    = out_data.humidity;
	assign res_ch.temperature = out_data.temperature;
	assign res_ch.noise       = out_data.noise;

`ifndef SYNTHESIS
	// byte count never runs past the idle value
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_index_q <= IDX_IDLE)
		else $error("byte count beyond frame length");

	// a link failure leaves the block idle
	a_fail_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && failed) |=> (byte_index_q == IDX_IDLE))
		else $error("receive failure did not idle the frame");

	// any request that yields a result leaves a result pending next cycle
	a_push_valid: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> res_ch.valid)
		else $error("result lost after last byte");

	// an ignored idle byte changes no frame state
	a_idle_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !failed && !req_ch.frame_start && byte_index_q == IDX_IDLE)
		|=> $stable(byte_index_q) && $stable(crc_q))
		else $error("idle byte altered frame state");
`endif

endmodule

`default_nettype wire
